/* design/rle8_decompress_crc32_check_defines.svh */
// Assertion macros for the RLE8 decompressor with CRC-32 check.
`ifndef RLE8_DECOMPRESS_CRC32_CHECK_DEFINES_SVH
`define RLE8_DECOMPRESS_CRC32_CHECK_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/rle8crc_pkg.sv */
// Shared types, constants and the CRC-32 byte update for the RLE8 decompressor.
package rle8crc_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [7:0]  RUN_FLAG = 8'd128;
	localparam logic [7:0]  RUN_MASK = 8'h7F;
	localparam logic [7:0]  RUN_BIAS = 8'd3;

	localparam logic [1:0] MODE_STORED = 2'd0;
	localparam logic [1:0] MODE_RLE8   = 2'd1;

	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_CSIZE = 2'd1;
	localparam logic [1:0] REG_DSIZE = 2'd2;
	localparam logic [1:0] REG_ECRC  = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DECODE  = 2'd1;
	localparam logic [1:0] ST_BAD_CFG = 2'd2;
	localparam logic [1:0] ST_CRC     = 2'd3;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [1:0] {
		PH_CTRL = 2'd0,
		PH_LIT  = 2'd1,
		PH_RUN  = 2'd2
	} phase_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic crc_step;
		logic load_data;
		logic load_stat;
	} dp_cmd_t;

	typedef struct packed {
		logic skip;
		logic run;
		logic have;
		logic last;
		logic run_last;
		logic out_free;
	} dp_stat_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] v);
		logic [31:0] x;
		x = c ^ {24'd0, v};
		for (int b = 0; b < 8; b++) begin
			x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
		end
		return x;
	endfunction

endpackage

/* design/rle8crc_ctrl.sv */
// Sequencer for the RLE8 decompressor: capture, decide, run CRC loop, emit results.
module rle8crc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output rle8crc_pkg::dp_cmd_t cmd,
	input  rle8crc_pkg::dp_stat_t stat
);
	import rle8crc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EVAL = 5'b00010,
		S_RUN  = 5'b00100,
		S_DATA = 5'b01000,
		S_STAT = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (stat.skip) begin
					state_d = S_IDLE;
				end else if (stat.run) begin
					state_d = S_RUN;
				end else if (stat.have) begin
					state_d = S_DATA;
				end else if (stat.last) begin
					state_d = S_STAT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_RUN: begin
				cmd.crc_step = 1'b1;
				if (stat.run_last) begin
					state_d = S_DATA;
				end
			end
			S_DATA: begin
				if (stat.out_free) begin
					cmd.load_data = 1'b1;
					state_d       = stat.last ? S_STAT : S_IDLE;
				end
			end
			S_STAT: begin
				if (stat.out_free) begin
					cmd.load_stat = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* design/rle8crc_dp.sv */
// Datapath: config registers, decode state, CRC register and output word register.
module rle8crc_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic [7:0]            in_byte,
	input  rle8crc_pkg::dp_cmd_t  cmd,
	output rle8crc_pkg::dp_stat_t stat,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic                  result_kind,
	output logic [7:0]            out_byte,
	output logic [7:0]            repeat_count,
	output logic [1:0]            status_code,
	output logic [31:0]           computed_crc,
	output logic                  last_of_item
);
	import rle8crc_pkg::*;

	// configuration
	logic [1:0]  mode_q;
	logic [31:0] csize_q;
	logic [31:0] dsize_q;
	logic [31:0] ecrc_q;

	// decode state
	logic [31:0] bytes_taken_q;
	logic [31:0] bytes_made_q;
	logic [31:0] crc_q;
	phase_t      phase_q;
	logic [7:0]  lit_left_q;
	logic [1:0]  err_q;
	logic [7:0]  rep_q;
	logic [7:0]  cnt_q;

	// captured word and precomputed margins
	logic [7:0]  byte_s1;
	logic [31:0] room_s1;
	logic [31:0] left_s1;
	logic        skip_s1;
	logic        last_s1;

	// output word
	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  obyte_q;
	logic [7:0]  orep_q;
	logic [1:0]  ost_q;
	logic [31:0] ocrc_q;
	logic        olast_q;

	// decision
	logic        mode_bad;
	logic [1:0]  err_in;
	logic [1:0]  err_n;
	logic        room_zero;
	logic [7:0]  lit_len;
	logic [7:0]  run_len;
	logic        have;
	logic        run;
	logic [7:0]  len_n;
	phase_t      phase_n;
	logic [7:0]  lit_n;
	logic [31:0] crc_fin;
	logic [1:0]  st_fin;

	always_comb begin
		mode_bad  = (mode_q > MODE_RLE8) || (mode_q == MODE_STORED && csize_q != dsize_q);
		err_in    = (err_q != ST_OK) ? err_q : (mode_bad ? ST_BAD_CFG : ST_OK);
		room_zero = (room_s1 == 32'd0);
		lit_len   = (byte_s1 & RUN_MASK) + 8'd1;
		run_len   = (byte_s1 & RUN_MASK) + RUN_BIAS;
		err_n     = err_in;
		have      = 1'b0;
		run       = 1'b0;
		len_n     = 8'd1;
		phase_n   = phase_q;
		lit_n     = lit_left_q;
		if (err_in == ST_OK) begin
			if (mode_q == MODE_STORED) begin
				if (room_zero) begin
					err_n = ST_DECODE;
				end else begin
					have = 1'b1;
				end
			end else begin
				case (phase_q)
					PH_LIT: begin
						if (room_zero) begin
							err_n = ST_DECODE;
						end else begin
							have  = 1'b1;
							lit_n = lit_left_q - 8'd1;
							if (lit_n == 8'd0) begin
								phase_n = PH_CTRL;
							end
						end
					end
					PH_RUN: begin
						if ({24'd0, lit_left_q} > room_s1) begin
							err_n = ST_DECODE;
						end else begin
							run     = 1'b1;
							len_n   = lit_left_q;
							lit_n   = 8'd0;
							phase_n = PH_CTRL;
						end
					end
					default: begin
						if (room_zero) begin
							err_n = ST_DECODE;
						end else if (byte_s1 < RUN_FLAG) begin
							if ({24'd0, lit_len} > left_s1 || {24'd0, lit_len} > room_s1) begin
								err_n = ST_DECODE;
							end else begin
								lit_n   = lit_len;
								phase_n = PH_LIT;
							end
						end else begin
							if (left_s1 == 32'd0 || {24'd0, run_len} > room_s1) begin
								err_n = ST_DECODE;
							end else begin
								lit_n   = run_len;
								phase_n = PH_RUN;
							end
						end
					end
				endcase
			end
		end
	end

	// final status from committed state
	always_comb begin
		crc_fin = ~crc_q;
		if (err_q != ST_OK) begin
			st_fin = err_q;
		end else if (phase_q != PH_CTRL || bytes_made_q != dsize_q) begin
			st_fin = ST_DECODE;
		end else if (crc_fin != ecrc_q) begin
			st_fin = ST_CRC;
		end else begin
			st_fin = ST_OK;
		end
	end

	always_comb begin
		stat.skip     = skip_s1;
		stat.run      = run && !skip_s1;
		stat.have     = have && !skip_s1;
		stat.last     = last_s1;
		stat.run_last = (cnt_q == 8'd1);
		stat.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_STORED;
			csize_q       <= 32'd1;
			dsize_q       <= 32'd0;
			ecrc_q        <= 32'd0;
			bytes_taken_q <= 32'd0;
			bytes_made_q  <= 32'd0;
			crc_q         <= CRC_INIT;
			phase_q       <= PH_CTRL;
			lit_left_q    <= 8'd0;
			err_q         <= ST_OK;
			cnt_q         <= 8'd0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:  mode_q  <= cfg_data[1:0];
					REG_CSIZE: csize_q <= cfg_data;
					REG_DSIZE: dsize_q <= cfg_data;
					REG_ECRC:  ecrc_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.eval && !skip_s1) begin
				bytes_taken_q <= bytes_taken_q + 32'd1;
				err_q         <= err_n;
				phase_q       <= phase_n;
				lit_left_q    <= lit_n;
				if (have) begin
					crc_q        <= crc_byte(crc_q, byte_s1);
					bytes_made_q <= bytes_made_q + 32'd1;
				end
				if (run) begin
					bytes_made_q <= bytes_made_q + {24'd0, len_n};
					cnt_q        <= len_n;
				end
			end
			if (cmd.crc_step) begin
				crc_q <= crc_byte(crc_q, byte_s1);
				cnt_q <= cnt_q - 8'd1;
			end
			if (cmd.load_data || cmd.load_stat) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_s1 <= in_byte;
			skip_s1 <= (bytes_taken_q >= csize_q);
			last_s1 <= (bytes_taken_q + 32'd1 == csize_q);
			left_s1 <= csize_q - bytes_taken_q - 32'd1;
			room_s1 <= (bytes_made_q <= dsize_q) ? (dsize_q - bytes_made_q) : 32'd0;
		end
		if (cmd.eval && !skip_s1) begin
			rep_q <= len_n;
		end
		if (cmd.load_data) begin
			kind_q  <= KIND_DATA;
			obyte_q <= byte_s1;
			orep_q  <= rep_q;
			ost_q   <= ST_OK;
			ocrc_q  <= 32'd0;
			olast_q <= !last_s1;
		end else if (cmd.load_stat) begin
			kind_q  <= KIND_STATUS;
			obyte_q <= 8'd0;
			orep_q  <= 8'd0;
			ost_q   <= st_fin;
			ocrc_q  <= crc_fin;
			olast_q <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign out_byte     = obyte_q;
	assign repeat_count = orep_q;
	assign status_code  = ost_q;
	assign computed_crc = ocrc_q;
	assign last_of_item = olast_q;

endmodule

/* design/rle8_decompress_crc32_check.sv */
// Steps: a control or ignored byte is accepted and evaluated; a literal or stored byte is
// accepted and evaluated, then its data word is loaded; a run value byte is accepted and
// evaluated, then the CRC loop updates one repeated byte per cycle for the run length
// (3..130) before its data word is loaded. A status word follows the data word, if any.
// A new byte is accepted once all its words sit in the output register.
// Reset (arst_n low, asynchronous): idle, counters and error cleared, CRC all ones.
`include "rle8_decompress_crc32_check_defines.svh"

module rle8_decompress_crc32_check (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// compressed input words
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	// result words
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [7:0]  out_byte,
	output logic [7:0]  repeat_count,
	output logic [1:0]  status_code,
	output logic [31:0] computed_crc,
	output logic        last_of_item
);
	import rle8crc_pkg::*;

	// command and status between sequencer and datapath
	dp_cmd_t  cmd;
	dp_stat_t dp_stat;

	// sequencer: one input word in flight at a time
	rle8crc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (dp_stat)
	);

	// datapath: decode state, CRC, output word register
	rle8crc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_byte      (in_byte),
		.cmd          (cmd),
		.stat         (dp_stat),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.result_kind  (result_kind),
		.out_byte     (out_byte),
		.repeat_count (repeat_count),
		.status_code  (status_code),
		.computed_crc (computed_crc),
		.last_of_item (last_of_item)
	);

	// an accepted word is evaluated before the next one is taken
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready)
	// status word always closes its input word
	`ASSERT_IMPL(a_status_last, clk, arst_n, out_valid && result_kind == KIND_STATUS, last_of_item)
	// data words carry a nonzero repeat and no status fields
	`ASSERT_IMPL(a_data_clean, clk, arst_n, out_valid && result_kind == KIND_DATA, status_code == ST_OK && computed_crc == 32'd0 && repeat_count != 8'd0)
	// the output register is loaded only when free
	`ASSERT_IMPL(a_load_free, clk, arst_n, cmd.load_data || cmd.load_stat, dp_stat.out_free)

endmodule

/* tb/rle8_decompress_crc32_check_test.sv */
// Self-checking testbench for the RLE8 decompressor with CRC-32 check.
`timescale 1ns / 1ps

module rle8_decompress_crc32_check_test;
	import rle8crc_pkg::*;

	// mode codes the block must reject
	localparam logic [1:0] MODE_BAD_LO = 2'd2;
	localparam logic [1:0] MODE_BAD_HI = 2'd3;

	// one result word as the block presents it
	typedef struct packed {
		logic        kind;
		logic [7:0]  value;
		logic [7:0]  copies;
		logic [1:0]  status;
		logic [31:0] crc;
		logic        last;
	} word_t;

	// sticky fault provoked at the very end; only one can be seen per run since
	// the error code survives everything but reset
	typedef enum logic [2:0] {
		FAULT_MODE,
		FAULT_STORED_SIZE,
		FAULT_LIT_OVER,
		FAULT_RUN_OVER,
		FAULT_FULL_CTRL,
		FAULT_LIT_UNDER,
		FAULT_RUN_LAST
	} fault_t;

	// Decoder model plus the queue of words it predicts.
	class rle8_crc_scoreboard;
		// registers
		logic [1:0]  mode;
		logic [31:0] csize;
		logic [31:0] dsize;
		logic [31:0] ecrc;
		// decode state, never cleared after reset
		logic [31:0] taken;
		logic [31:0] made;
		logic [31:0] crc_reg;
		phase_t      phase;
		logic [7:0]  lit_left;
		logic [1:0]  err;

		word_t words_due[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned bytes_in;
		int unsigned data_words;
		int unsigned status_hits[4];

		function new();
			mode = MODE_STORED;
			csize = 32'd1;
			dsize = 32'd0;
			ecrc = 32'd0;
			taken = 32'd0;
			made = 32'd0;
			crc_reg = CRC_INIT;
			phase = PH_CTRL;
			lit_left = 8'd0;
			err = ST_OK;
		endfunction

		// reflected CRC-32, one byte
		static function logic [31:0] crc8(input logic [31:0] c, input logic [7:0] v);
			logic [31:0] r;
			r = c ^ {24'd0, v};
			repeat (8) begin
				if (r[0])
					r = (r >> 1) ^ CRC_POLY;
				else
					r = r >> 1;
			end
			return r;
		endfunction

		function void write_reg(input logic [1:0] idx, input logic [31:0] d);
			case (idx)
				REG_MODE: mode = d[1:0];
				REG_CSIZE: csize = d;
				REG_DSIZE: dsize = d;
				REG_ECRC: ecrc = d;
				default: ;
			endcase
		endfunction

		function void latch_error(input logic [1:0] code);
			if (err == ST_OK)
				err = code;
		endfunction

		// Advance the decoder by one accepted byte and queue the words it causes.
		function void decode_byte(input logic [7:0] v);
			logic [31:0] room;
			logic [31:0] left_in;
			logic [31:0] len;
			logic        have;
			word_t       dw;
			word_t       sw;
			bytes_in++;
			if (taken >= csize)
				return;		// stream done, byte dropped
			left_in = csize - taken - 32'd1;
			taken++;
			room = (made <= dsize) ? dsize - made : 32'd0;
			have = 1'b0;
			dw = '0;
			sw = '0;

			if (mode > MODE_RLE8)
				latch_error(ST_BAD_CFG);
			else if (mode == MODE_STORED && csize != dsize)
				latch_error(ST_BAD_CFG);

			if (err == ST_OK) begin
				if (mode == MODE_STORED || phase == PH_LIT) begin
					if (room == 32'd0) begin
						latch_error(ST_DECODE);
					end else begin
						crc_reg = crc8(crc_reg, v);
						made++;
						have = 1'b1;
						dw.value = v;
						dw.copies = 8'd1;
						if (mode != MODE_STORED) begin
							lit_left = lit_left - 8'd1;
							if (lit_left == 8'd0)
								phase = PH_CTRL;
						end
					end
				end else if (phase == PH_RUN) begin
					len = {24'd0, lit_left};
					if (len > room) begin
						latch_error(ST_DECODE);
					end else begin
						repeat (len) crc_reg = crc8(crc_reg, v);
						made += len;
						have = 1'b1;
						dw.value = v;
						dw.copies = lit_left;
						lit_left = 8'd0;
						phase = PH_CTRL;
					end
				end else if (room == 32'd0) begin
					latch_error(ST_DECODE);	// control byte with output already full
				end else if (v < RUN_FLAG) begin
					len = {24'd0, v} + 32'd1;
					if (len > left_in || len > room) begin
						latch_error(ST_DECODE);
					end else begin
						lit_left = len[7:0];
						phase = PH_LIT;
					end
				end else begin
					len = {24'd0, v & RUN_MASK} + {24'd0, RUN_BIAS};
					if (left_in == 32'd0 || len > room) begin
						latch_error(ST_DECODE);
					end else begin
						lit_left = len[7:0];
						phase = PH_RUN;
					end
				end
			end

			if (taken == csize) begin
				sw.kind = KIND_STATUS;
				sw.crc = ~crc_reg;
				if (err != ST_OK)
					sw.status = err;
				else if (phase != PH_CTRL || made != dsize)
					sw.status = ST_DECODE;
				else if (sw.crc != ecrc)
					sw.status = ST_CRC;
				else
					sw.status = ST_OK;
				sw.last = 1'b1;
				status_hits[sw.status]++;
			end else if (have) begin
				dw.last = 1'b1;
			end

			if (have) begin
				dw.kind = KIND_DATA;
				data_words++;
				words_due.push_back(dw);
			end
			if (taken == csize && sw.kind == KIND_STATUS)
				words_due.push_back(sw);
		endfunction

		function void report(input string what, input word_t want, input word_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: %s", $time, what);
				$display("  expected kind=%0d byte=%02h count=%0d status=%0d crc=%08h last=%0d",
					want.kind, want.value, want.copies, want.status, want.crc, want.last);
				$display("  actual   kind=%0d byte=%02h count=%0d status=%0d crc=%08h last=%0d",
					got.kind, got.value, got.copies, got.status, got.crc, got.last);
			end
		endfunction

		function void compare_word(input word_t got);
			word_t want;
			checked++;
			if (words_due.size() == 0) begin
				report("word with nothing expected", '0, got);
				return;
			end
			want = words_due.pop_front();
			if (got !== want)
				report("word differs", want, got);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_MODE;
	logic [31:0] cfg_data = 32'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        result_kind;
	logic [7:0]  out_byte;
	logic [7:0]  repeat_count;
	logic [1:0]  status_code;
	logic [31:0] computed_crc;
	logic        last_of_item;

	rle8_crc_scoreboard sb = new();

	// idle bursts on both sides; calm switches them off for the tail of the run
	bit          bursts_on = 1'b0;
	bit          calm = 1'b0;
	int unsigned stall_left = 0;
	int unsigned items_sent = 0;

	// compressed bytes of the segment being built, how many bytes they decode
	// to, and the running CRC through them
	logic [7:0]  seg_bytes[$];
	logic [31:0] seg_out;
	logic [31:0] seg_crc;

	rle8_decompress_crc32_check dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.out_byte(out_byte),
		.repeat_count(repeat_count),
		.status_code(status_code),
		.computed_crc(computed_crc),
		.last_of_item(last_of_item)
	);

	always #10 clk = ~clk;

	// Result side: take a word on each handshake, then decide ready for the
	// next cycle. Values read here are the ones from before the edge.
	always @(posedge clk) begin : result_sink
		word_t got;
		if (arst_n && out_valid && out_ready) begin
			got.kind = result_kind;
			got.value = out_byte;
			got.copies = repeat_count;
			got.status = status_code;
			got.crc = computed_crc;
			got.last = last_of_item;
			sb.compare_word(got);
		end
		if (stall_left != 0)
			stall_left = stall_left - 1;
		else if (bursts_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 10);
		out_ready <= (stall_left == 0);
	end

	// One compressed word. Valid stays up between words; it only drops for a gap.
	task automatic send_byte(input logic [7:0] v);
		if (bursts_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.decode_byte(v);
	endtask

	// Wait for every predicted word, then for tail cycles for a control or dropped
	// byte still being evaluated (those give no word to wait on).
	task automatic settle(input int unsigned tail);
		in_valid <= 1'b0;
		while (sb.words_due.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic put_reg(input logic [1:0] idx, input logic [31:0] d);
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		sb.write_reg(idx, d);
	endtask

	// all four registers, back to back; only while the block is idle
	task automatic set_stream(input logic [1:0] mode, input logic [31:0] csize,
			input logic [31:0] dsize, input logic [31:0] crc);
		cfg_we <= 1'b1;
		put_reg(REG_MODE, {30'd0, mode});
		put_reg(REG_CSIZE, csize);
		put_reg(REG_DSIZE, dsize);
		put_reg(REG_ECRC, crc);
		cfg_we <= 1'b0;
	endtask

	// bytes past the end of the stream: the block must drop them silently
	task automatic noise(input int unsigned n);
		repeat (n) send_byte(8'($urandom));
		settle(8);
	endtask

	// plain byte: a stored byte, or a literal after its control byte
	function automatic void put_plain(input logic [7:0] v);
		seg_bytes.push_back(v);
		seg_out++;
		seg_crc = rle8_crc_scoreboard::crc8(seg_crc, v);
	endfunction

	function automatic void put_literal(input int unsigned n);
		seg_bytes.push_back(8'(n - 1));
		repeat (n) put_plain(8'($urandom));
	endfunction

	function automatic void put_run(input int unsigned n, input logic [7:0] v);
		seg_bytes.push_back(RUN_FLAG | (8'(n) - RUN_BIAS));
		seg_bytes.push_back(v);
		repeat (n) seg_crc = rle8_crc_scoreboard::crc8(seg_crc, v);
		seg_out += n;
	endfunction

	// Start a segment from the decoder's live state; a literal or run left open
	// by an earlier stream end gets finished first.
	function automatic void open_segment();
		seg_bytes.delete();
		seg_out = 32'd0;
		seg_crc = sb.crc_reg;
		if (sb.phase == PH_LIT) begin
			repeat (sb.lit_left) put_plain(8'($urandom));
		end else if (sb.phase == PH_RUN) begin
			seg_bytes.push_back(8'($urandom));
			repeat (sb.lit_left) seg_crc = rle8_crc_scoreboard::crc8(seg_crc, seg_bytes[$]);
			seg_out += sb.lit_left;
		end
	endfunction

	// decoded size that the segment exactly fills
	function automatic logic [31:0] full_size();
		return sb.made + seg_out;
	endfunction

	// Configure a stream that ends on the segment's last byte and push it through.
	task automatic play_segment(input logic [1:0] mode, input logic [31:0] dsize,
			input bit crc_bad);
		logic [31:0] crc_want;
		crc_want = ~seg_crc;
		if (crc_bad)
			crc_want ^= 32'd1 << $urandom_range(0, 31);
		bursts_on = !calm && ($urandom_range(0, 3) != 0);
		set_stream(mode, sb.taken + seg_bytes.size(), dsize, crc_want);
		foreach (seg_bytes[i]) send_byte(seg_bytes[i]);
		items_sent += seg_bytes.size();
		settle(8);
	endtask

	// hard stop
	initial begin
		#(64'd20_000_000);
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [31:0] dsize;
		logic [1:0]  mode;
		fault_t      fault;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed ----
		// stored stream, equal sizes, byte extremes
		open_segment();
		put_plain(8'h00);
		put_plain(8'hFF);
		put_plain(8'h5A);
		put_plain(8'hA5);
		play_segment(MODE_STORED, sb.taken + seg_bytes.size(), 1'b0);
		noise(2);

		// shortest literal, longest and shortest runs
		open_segment();
		put_literal(1);
		put_run(130, 8'hFF);
		put_run(3, 8'h00);
		put_literal(3);
		play_segment(MODE_RLE8, full_size(), 1'b0);

		// CRC mismatch
		open_segment();
		put_literal(2);
		play_segment(MODE_RLE8, full_size(), 1'b1);

		// fewer decoded bytes than the decoded size
		open_segment();
		put_run(3, 8'($urandom));
		play_segment(MODE_RLE8, full_size() + 32'd2, 1'b0);

		// stream that ends inside a literal: open the stream wide, take the
		// control byte, then move the end up to the next byte
		bursts_on = 1'b0;
		set_stream(MODE_RLE8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_byte(8'd2);
		settle(8);
		set_stream(MODE_RLE8, sb.taken + 32'd1, 32'hFFFF_FFFF, 32'd0);
		send_byte(8'($urandom));
		settle(8);
		items_sent += 2;

		// zero compressed size: everything dropped, even with a bad mode
		set_stream(MODE_BAD_LO, 32'd0, 32'd0, 32'd0);
		noise(2);
		set_stream(MODE_BAD_HI, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		noise(2);

		// finish the open literal and go on
		open_segment();
		put_run(3, 8'($urandom));
		play_segment(MODE_RLE8, full_size(), 1'b0);

		// ---- random streams ----
		// mostly well-formed RLE8; stored when the counters allow it; some bad
		// CRCs, some short outputs, and dropped bytes between streams
		while (items_sent < 600) begin
			if (items_sent > 480)
				calm = 1'b1;
			open_segment();
			if (sb.made <= sb.taken && $urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 12)) put_plain(8'($urandom));
				mode = MODE_STORED;
				dsize = sb.taken + seg_bytes.size();
			end else begin
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 3) != 0 && (sb.made + seg_out > sb.taken
							|| $urandom_range(0, 1) == 0)) begin
						if ($urandom_range(0, 24) == 0)
							put_literal($urandom_range(1, 128));
						else
							put_literal($urandom_range(1, 6));
					end else begin
						if ($urandom_range(0, 19) == 0)
							put_run($urandom_range(3, 130), 8'($urandom));
						else
							put_run($urandom_range(3, 12), 8'($urandom));
					end
				end
				mode = MODE_RLE8;
				dsize = full_size();
				if ($urandom_range(0, 7) == 0)
					dsize += $urandom_range(1, 3);
			end
			play_segment(mode, dsize, $urandom_range(0, 5) == 0);
			if ($urandom_range(0, 3) == 0)
				noise($urandom_range(1, 4));
		end

		// ---- one sticky fault, then a stream that must report it ----
		fault = fault_t'($urandom_range(0, 6));
		open_segment();
		case (fault)
			FAULT_MODE: begin
				put_literal(2);
				put_run(4, 8'($urandom));
				play_segment($urandom_range(0, 1) ? MODE_BAD_HI : MODE_BAD_LO, full_size(), 1'b0);
			end
			FAULT_STORED_SIZE: begin
				repeat (3) put_plain(8'($urandom));
				play_segment(MODE_STORED, sb.taken + seg_bytes.size() + 32'd1, 1'b0);
			end
			FAULT_LIT_OVER: begin
				put_literal(4);
				play_segment(MODE_RLE8, full_size() - 32'd2, 1'b0);
			end
			FAULT_RUN_OVER: begin
				put_run(10, 8'($urandom));
				play_segment(MODE_RLE8, full_size() - 32'd1, 1'b0);
			end
			FAULT_FULL_CTRL: begin
				put_literal(2);
				put_literal(1);		// its control byte finds the output full
				play_segment(MODE_RLE8, full_size() - 32'd1, 1'b0);
			end
			FAULT_LIT_UNDER: begin
				seg_bytes.push_back(8'd4);	// five literals promised, two follow
				put_plain(8'($urandom));
				put_plain(8'($urandom));
				play_segment(MODE_RLE8, full_size() + 32'd8, 1'b0);
			end
			default: begin
				put_literal(1);
				seg_bytes.push_back(RUN_FLAG | 8'($urandom_range(0, 127)));
				play_segment(MODE_RLE8, full_size() + 32'd5, 1'b0);
			end
		endcase
		open_segment();
		put_literal(3);
		put_run(5, 8'($urandom));
		play_segment(MODE_RLE8, full_size(), 1'b0);
		noise(3);

		// longest run plus status both fit well inside this tail
		settle(150);

		$display("%0d compressed words offered, %0d result words checked (%0d data)",
			sb.bytes_in, sb.checked, sb.data_words);
		$display("status ok/decode/config/crc = %0d/%0d/%0d/%0d, closing fault %s",
			sb.status_hits[ST_OK], sb.status_hits[ST_DECODE], sb.status_hits[ST_BAD_CFG],
			sb.status_hits[ST_CRC], fault.name());
		if (sb.mismatches == 0 && sb.words_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
